// ----- rtl/sosl_pkg.sv -----
// Shared types and constants of the scan obstacle steer limiter.
package sosl_pkg;

    // Field widths fixed by the item formats
    localparam int RANGE_W   = 16;
    localparam int HEAD_W    = 14;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ANG_W     = 16;
    localparam int RATE_W    = 17;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SKIP_DIST   = 3'd0,
        REG_FRONT_AVOID = 3'd1,
        REG_SIDE_AVOID  = 3'd2,
        REG_MAX_LINEAR  = 3'd3,
        REG_MAX_ANGULAR = 3'd4,
        REG_TURN_GAIN   = 3'd5,
        REG_ANGLE_STEP  = 3'd6
    } cfg_idx_t;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SKIP_DIST   = 16'd100;
    localparam logic [CFG_W-1:0] RST_FRONT_AVOID = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SIDE_AVOID  = 16'd500;
    localparam logic [CFG_W-1:0] RST_MAX_LINEAR  = 16'd500;
    localparam logic [CFG_W-1:0] RST_MAX_ANGULAR = 16'd1000;
    localparam logic [CFG_W-1:0] RST_TURN_GAIN   = 16'd256;
    localparam logic [CFG_W-1:0] RST_ANGLE_STEP  = 16'd6136;

    // Angle constants in mrad
    localparam int HALF_TURN_MRAD  = 3142;
    localparam int FULL_TURN_MRAD  = 6283;
    localparam int TIER_STOP_MRAD  = 1000;
    localparam int TIER_HALF_MRAD  = 500;
    localparam int FRONT_CONE_MRAD = 523;
    localparam int SIDE_CONE_MRAD  = 2094;
    localparam int FRONT_STEER     = 300;
    localparam int SIDE_STEER      = 200;

    // urad to mrad conversion with rounding
    localparam int DIV_MILLI  = 1000;
    localparam int ROUND_HALF = 500;

    // Divide by five: floor(x * DIV5_MUL >> DIV5_SHIFT) is exact for x < 2^18
    localparam int              DIV5_IN_W  = 18;
    localparam logic [18:0]     DIV5_MUL   = 19'd419431;
    localparam int              DIV5_SHIFT = 21;

    // Speed scaling choice
    typedef enum logic [1:0] {
        SCALE_NONE,
        SCALE_FOUR_FIFTHS,
        SCALE_THREE_FIFTHS
    } scale_t;

    // Configuration register file
    typedef struct packed {
        logic [CFG_W-1:0] skip_dist;
        logic [CFG_W-1:0] front_avoid;
        logic [CFG_W-1:0] side_avoid;
        logic [CFG_W-1:0] max_linear;
        logic [CFG_W-1:0] max_angular;
        logic [CFG_W-1:0] turn_gain;
        logic [CFG_W-1:0] angle_step;
    } cfg_t;

    // Item tag carried down the pipeline
    typedef struct packed {
        logic              steer;
        logic [HEAD_W-1:0] heading;
    } tag_t;

    // Stage load strobes
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic leave3;
        logic load4;
        logic load_out;
    } pipe_ctl_t;

endpackage

// ----- rtl/sosl_item_if.sv -----
// Input item channel: valid, ready and the request payload.
interface sosl_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] range_mm;
    logic        last_sample;
    logic [13:0] heading_error_mrad;

    modport source (
        output valid, op, range_mm, last_sample, heading_error_mrad,
        input  ready
    );
    modport sink (
        input  valid, op, range_mm, last_sample, heading_error_mrad,
        output ready
    );
endinterface

// ----- rtl/sosl_result_if.sv -----
// Result item channel: valid, ready and the command payload.
interface sosl_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] linear_mm_s;
    logic [16:0] angular_mrad_s;
    logic [15:0] obstacle_mm;
    logic [15:0] obstacle_angle_mrad;

    modport source (
        output valid, linear_mm_s, angular_mrad_s, obstacle_mm, obstacle_angle_mrad,
        input  ready
    );
    modport sink (
        input  valid, linear_mm_s, angular_mrad_s, obstacle_mm, obstacle_angle_mrad,
        output ready
    );
endinterface

// ----- rtl/sosl_scan_track.sv -----
// Scan tracker: running minimum, sample counter and danger index offset.
module sosl_scan_track #(
    parameter int MAX_SCAN_SAMPLES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        op,
    input  logic [sosl_pkg::RANGE_W-1:0] range_mm,
    input  logic                        last_sample,
    input  logic [sosl_pkg::CFG_W-1:0]  skip_dist,
    output logic                        last_reg,
    output logic                        neg_reg,
    output logic [$clog2(MAX_SCAN_SAMPLES)-1:0] absdiff_reg,
    output logic [sosl_pkg::RANGE_W-1:0] dist_reg
);
    localparam int CNT_W = $clog2(MAX_SCAN_SAMPLES);

    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             min_index_reg, min_index_next;
    logic [sosl_pkg::RANGE_W-1:0] min_range_reg, min_range_next;
    logic                         scan_load;
    logic                         last_next;
    logic [CNT_W:0]               half_wide;
    logic [CNT_W-1:0]             half;
    logic [CNT_W:0]               diff;
    logic                         neg_next;
    logic [CNT_W-1:0]             absdiff_next;

    assign scan_load = load && !op;
    assign last_next = !op && last_sample;

    // Update the running minimum; sample 0 always seeds it
    always_comb
    begin
        min_index_next = min_index_reg;
        min_range_next = min_range_reg;
        if (count_reg == '0)
        begin
            min_index_next = '0;
            min_range_next = range_mm;
        end
        else if (range_mm < min_range_reg && range_mm > skip_dist)
        begin
            min_index_next = count_reg;
            min_range_next = range_mm;
        end
    end

    // Advance the counter, hold at the final index, restart after the last sample
    always_comb
    begin
        count_next = count_reg;
        if (last_sample)
            count_next = '0;
        else if (count_reg < CNT_W'(MAX_SCAN_SAMPLES - 1))
            count_next = count_reg + 1'b1;
    end

    // Offset of the minimum from the scan center, as sign and magnitude
    always_comb
    begin
        half_wide    = ({1'b0, count_reg} + (CNT_W+1)'(1)) >> 1;
        half         = half_wide[CNT_W-1:0];
        diff         = {1'b0, min_index_next} - {1'b0, half};
        neg_next     = diff[CNT_W];
        absdiff_next = neg_next ? CNT_W'(-diff) : diff[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_index_reg <= '0;
            min_range_reg <= '0;
        end
        else if (scan_load)
        begin
            count_reg     <= count_next;
            min_index_reg <= min_index_next;
            min_range_reg <= min_range_next;
        end
    end

    // Stage payload toward the angle divider
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg    <= last_next;
            neg_reg     <= neg_next;
            absdiff_reg <= absdiff_next;
            dist_reg    <= min_range_next;
        end
    end

endmodule

// ----- rtl/sosl_angle_div.sv -----
// Danger angle: offset times step, rounded divide by 1000, saturate, latch danger.
module sosl_angle_div #(
    parameter int MAX_SCAN_SAMPLES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sosl_pkg::pipe_ctl_t           ctl,
    input  logic                          last_in,
    input  logic                          neg_in,
    input  logic [$clog2(MAX_SCAN_SAMPLES)-1:0] absdiff_in,
    input  logic [sosl_pkg::RANGE_W-1:0]  dist_in,
    input  logic [sosl_pkg::CFG_W-1:0]    angle_step,
    output logic [sosl_pkg::RANGE_W-1:0]  danger_dist,
    output logic [sosl_pkg::ANG_W-1:0]    danger_ang
);
    localparam int CNT_W = $clog2(MAX_SCAN_SAMPLES);
    localparam int XW    = CNT_W + 17;
    localparam int QW    = XW - 9;
    localparam int K     = XW + 1;
    localparam longint unsigned RECIP = (64'd1 << K) / 1000;
    localparam int MW    = $clog2(RECIP + 1);
    localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

    logic [CNT_W+15:0]            mag;
    logic [XW-1:0]                x_next, x2_reg, x3_reg;
    logic                         neg2_reg, neg3_reg;
    logic                         last2_reg, last3_reg;
    logic [sosl_pkg::RANGE_W-1:0] dist2_reg, dist3_reg;
    logic [XW+MW-1:0]             recip_prod;
    logic [QW-1:0]                q0_next, q0_reg;
    logic [XW-1:0]                back_prod;
    logic [XW-1:0]                rem;
    logic [QW:0]                  q_fix;
    logic [31:0]                  q32;
    logic [sosl_pkg::ANG_W-1:0]   ang_next;
    logic [sosl_pkg::RANGE_W-1:0] danger_dist_reg;
    logic [sosl_pkg::ANG_W-1:0]   danger_ang_reg;

    // Scale the offset and add the rounding half
    always_comb
    begin
        mag    = {{16{1'b0}}, absdiff_in} * {{CNT_W{1'b0}}, angle_step};
        x_next = XW'(mag) + XW'(sosl_pkg::ROUND_HALF);
    end

    // Quotient estimate by reciprocal, never above the true value
    always_comb
    begin
        recip_prod = {{MW{1'b0}}, x2_reg} * {{XW{1'b0}}, RECIP_V};
        q0_next    = QW'(recip_prod >> K);
    end

    // Correct by one step, then saturate with sign
    always_comb
    begin
        back_prod = XW'(q0_reg) * XW'(sosl_pkg::DIV_MILLI);
        rem       = x3_reg - back_prod;
        q_fix     = (QW+1)'(q0_reg) + (QW+1)'(rem >= XW'(sosl_pkg::DIV_MILLI));
        q32       = 32'(q_fix);
        if (neg3_reg)
            ang_next = (q32 > 32'd32768) ? 16'h8000 : 16'(32'd0 - q32);
        else
            ang_next = (q32 > 32'd32767) ? 16'h7FFF : q32[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
        begin
            x2_reg    <= x_next;
            neg2_reg  <= neg_in;
            last2_reg <= last_in;
            dist2_reg <= dist_in;
        end
        if (ctl.load3)
        begin
            q0_reg    <= q0_next;
            x3_reg    <= x2_reg;
            neg3_reg  <= neg2_reg;
            last3_reg <= last2_reg;
            dist3_reg <= dist2_reg;
        end
    end

    // Latch danger on the item that closes a scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_dist_reg <= '0;
            danger_ang_reg  <= '0;
        end
        else if (ctl.leave3 && last3_reg)
        begin
            danger_dist_reg <= dist3_reg;
            danger_ang_reg  <= ang_next;
        end
    end

    assign danger_dist = danger_dist_reg;
    assign danger_ang  = danger_ang_reg;

endmodule

// ----- rtl/sosl_steer.sv -----
// Steering: heading wrap, speed tier, avoidance overrides, rate scale and limit.
module sosl_steer (
    input  logic                          clk,
    input  sosl_pkg::pipe_ctl_t           ctl,
    input  logic [sosl_pkg::HEAD_W-1:0]   heading,
    input  logic [sosl_pkg::RANGE_W-1:0]  danger_dist,
    input  logic [sosl_pkg::ANG_W-1:0]    danger_ang,
    input  sosl_pkg::cfg_t                cfg,
    output logic [15:0]                   linear_reg,
    output logic [sosl_pkg::RATE_W-1:0]   rate_reg,
    output logic [sosl_pkg::RANGE_W-1:0]  dist_out_reg,
    output logic [sosl_pkg::ANG_W-1:0]    ang_out_reg
);
    logic signed [14:0]           e_ext, e_wrap;
    logic [14:0]                  e_mag, w_mag;
    logic [11:0]                  ae;
    logic [15:0]                  speed_next;
    logic [15:0]                  aang;
    logic                         away_neg;
    logic                         front_hit, side_hit, moving;
    logic [11:0]                  cmd_mag_next;
    logic                         cmd_neg_next;
    sosl_pkg::scale_t             scale_next;

    logic [11:0]                  cmd_mag_reg;
    logic                         cmd_neg_reg;
    logic [15:0]                  speed_reg;
    sosl_pkg::scale_t             scale_reg;
    logic [sosl_pkg::RANGE_W-1:0] dist4_reg;
    logic [sosl_pkg::ANG_W-1:0]   ang4_reg;

    logic [27:0]                  gain_prod;
    logic [19:0]                  rate_mag;
    logic [15:0]                  rate_sat;
    logic [sosl_pkg::RATE_W-1:0]  rate_next;
    logic [sosl_pkg::DIV5_IN_W-1:0] scaled;
    logic [36:0]                  div5_prod;
    logic [15:0]                  linear_next;

    // Wrap the heading error once into the half turn
    always_comb
    begin
        e_ext = $signed({heading[sosl_pkg::HEAD_W-1], heading});
        e_mag = e_ext[14] ? 15'(-e_ext) : 15'(e_ext);
        if (e_mag >= 15'(sosl_pkg::HALF_TURN_MRAD))
            e_wrap = e_ext[14] ? e_ext + 15'(sosl_pkg::FULL_TURN_MRAD)
                               : e_ext - 15'(sosl_pkg::FULL_TURN_MRAD);
        else
            e_wrap = e_ext;
        w_mag = e_wrap[14] ? 15'(-e_wrap) : 15'(e_wrap);
        ae    = w_mag[11:0];
    end

    // Pick the speed tier
    always_comb
    begin
        if (ae > 12'(sosl_pkg::TIER_STOP_MRAD))
            speed_next = '0;
        else if (ae > 12'(sosl_pkg::TIER_HALF_MRAD))
            speed_next = cfg.max_linear >> 1;
        else
            speed_next = cfg.max_linear;
    end

    // Apply avoidance overrides to steering and speed scale
    always_comb
    begin
        aang      = danger_ang[15] ? 16'(-danger_ang) : danger_ang;
        away_neg  = !danger_ang[15];
        moving    = (speed_next != '0);
        front_hit = (danger_dist < cfg.front_avoid) &&
                    (aang <= 16'(sosl_pkg::FRONT_CONE_MRAD));
        side_hit  = (danger_dist < cfg.side_avoid) &&
                    (aang <= 16'(sosl_pkg::SIDE_CONE_MRAD));

        cmd_mag_next = ae;
        cmd_neg_next = e_wrap[14];
        scale_next   = sosl_pkg::SCALE_NONE;
        if (moving)
        begin
            if (front_hit)
            begin
                cmd_mag_next = 12'(sosl_pkg::FRONT_STEER);
                cmd_neg_next = away_neg;
            end
            else if (side_hit)
            begin
                cmd_mag_next = 12'(sosl_pkg::SIDE_STEER);
                cmd_neg_next = away_neg;
            end

            if (front_hit && danger_dist >= cfg.side_avoid)
                scale_next = sosl_pkg::SCALE_FOUR_FIFTHS;
            else if (side_hit)
                scale_next = sosl_pkg::SCALE_THREE_FIFTHS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load4)
        begin
            cmd_mag_reg <= cmd_mag_next;
            cmd_neg_reg <= cmd_neg_next;
            speed_reg   <= speed_next;
            scale_reg   <= scale_next;
            dist4_reg   <= danger_dist;
            ang4_reg    <= danger_ang;
        end
    end

    // Scale the steering into a rate and limit its magnitude
    always_comb
    begin
        gain_prod = {16'd0, cmd_mag_reg} * {12'd0, cfg.turn_gain};
        rate_mag  = gain_prod[27:8];
        rate_sat  = (rate_mag > {4'd0, cfg.max_angular}) ? cfg.max_angular : rate_mag[15:0];
        rate_next = cmd_neg_reg ? (sosl_pkg::RATE_W)'(-{1'b0, rate_sat})
                                : {1'b0, rate_sat};
    end

    // Scale the speed by three or four fifths, or pass it through unscaled
    always_comb
    begin
        case (scale_reg)
            sosl_pkg::SCALE_FOUR_FIFTHS:  scaled = {speed_reg, 2'b00};
            sosl_pkg::SCALE_THREE_FIFTHS: scaled = {1'b0, speed_reg, 1'b0} +
                                                   {2'b00, speed_reg};
            default:                      scaled = '0;
        endcase
        div5_prod = {19'd0, scaled} * {18'd0, sosl_pkg::DIV5_MUL};
        if (scale_reg == sosl_pkg::SCALE_NONE)
            linear_next = speed_reg;
        else
            linear_next = 16'(div5_prod >> sosl_pkg::DIV5_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            linear_reg   <= linear_next;
            rate_reg     <= rate_next;
            dist_out_reg <= dist4_reg;
            ang_out_reg  <= ang4_reg;
        end
    end

endmodule

// ----- rtl/scan_obstacle_steer_limiter_core.sv -----
// Scan obstacle steer limiter: top level with config registers and pipeline control.
//
// Accepts one item per clock while ready is high. A range sample (op 0) updates
// the running minimum of the current scan and produces no result. The sample
// marked last latches the danger distance and angle as it leaves the angle
// quotient stage. A steering request (op 1) yields one result, always seeing the
// danger values of every scan closed by samples accepted before it. The pipeline
// has six registered stages (input, scan tracker, angle product, angle quotient,
// steering select, output); stalled stages collapse bubbles, so ready drops only
// when the output register is held and every stage behind it is full.
// Configuration writes take effect on the next clock.
module scan_obstacle_steer_limiter_core #(
    parameter int MAX_SCAN_SAMPLES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sosl_item_if.sink                       item,
    sosl_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [sosl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sosl_pkg::CFG_W-1:0]      cfg_wdata
);
    localparam int CNT_W = $clog2(MAX_SCAN_SAMPLES);

    sosl_pkg::cfg_t                cfg_reg, cfg_next;
    sosl_pkg::pipe_ctl_t           ctl;

    logic                          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vout_reg;
    logic                          accept, leave0, leave1, leave2, leave3, load4, load_out;
    logic                          free_out;

    logic                          op0_reg;
    logic [sosl_pkg::RANGE_W-1:0]  range0_reg;
    logic                          last0_reg;
    logic [sosl_pkg::HEAD_W-1:0]   head0_reg;
    sosl_pkg::tag_t                t1_reg, t2_reg, t3_reg;

    logic                          s1_last, s1_neg;
    logic [CNT_W-1:0]              s1_absdiff;
    logic [sosl_pkg::RANGE_W-1:0]  s1_dist;
    logic [sosl_pkg::RANGE_W-1:0]  danger_dist;
    logic [sosl_pkg::ANG_W-1:0]    danger_ang;

    logic [15:0]                   linear_reg;
    logic [sosl_pkg::RATE_W-1:0]   rate_reg;
    logic [sosl_pkg::RANGE_W-1:0]  dist_out_reg;
    logic [sosl_pkg::ANG_W-1:0]    ang_out_reg;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sosl_pkg::cfg_idx_t'(cfg_index))
                sosl_pkg::REG_SKIP_DIST:   cfg_next.skip_dist   = cfg_wdata;
                sosl_pkg::REG_FRONT_AVOID: cfg_next.front_avoid = cfg_wdata;
                sosl_pkg::REG_SIDE_AVOID:  cfg_next.side_avoid  = cfg_wdata;
                sosl_pkg::REG_MAX_LINEAR:  cfg_next.max_linear  = cfg_wdata;
                sosl_pkg::REG_MAX_ANGULAR: cfg_next.max_angular = cfg_wdata;
                sosl_pkg::REG_TURN_GAIN:   cfg_next.turn_gain   = cfg_wdata;
                sosl_pkg::REG_ANGLE_STEP:  cfg_next.angle_step  = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_dist   <= sosl_pkg::RST_SKIP_DIST;
            cfg_reg.front_avoid <= sosl_pkg::RST_FRONT_AVOID;
            cfg_reg.side_avoid  <= sosl_pkg::RST_SIDE_AVOID;
            cfg_reg.max_linear  <= sosl_pkg::RST_MAX_LINEAR;
            cfg_reg.max_angular <= sosl_pkg::RST_MAX_ANGULAR;
            cfg_reg.turn_gain   <= sosl_pkg::RST_TURN_GAIN;
            cfg_reg.angle_step  <= sosl_pkg::RST_ANGLE_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance stages into free slots; scan items drop out after the quotient stage
    always_comb
    begin
        free_out = !vout_reg || result.ready;
        load_out = v4_reg && free_out;
        leave3   = v3_reg && (!t3_reg.steer || !v4_reg || load_out);
        load4    = leave3 && t3_reg.steer;
        leave2   = v2_reg && (!v3_reg || leave3);
        leave1   = v1_reg && (!v2_reg || leave2);
        leave0   = v0_reg && (!v1_reg || leave1);
        accept   = item.valid && item.ready;

        ctl.load1    = leave0;
        ctl.load2    = leave1;
        ctl.load3    = leave2;
        ctl.leave3   = leave3;
        ctl.load4    = load4;
        ctl.load_out = load_out;
    end

    assign item.ready = !v0_reg || leave0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept   ? 1'b1 : (leave0   ? 1'b0 : v0_reg);
            v1_reg   <= leave0   ? 1'b1 : (leave1   ? 1'b0 : v1_reg);
            v2_reg   <= leave1   ? 1'b1 : (leave2   ? 1'b0 : v2_reg);
            v3_reg   <= leave2   ? 1'b1 : (leave3   ? 1'b0 : v3_reg);
            v4_reg   <= load4    ? 1'b1 : (load_out ? 1'b0 : v4_reg);
            vout_reg <= load_out ? 1'b1 : (result.ready ? 1'b0 : vout_reg);
        end
    end

    // Hold the input item and carry its tag down the pipe
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op0_reg    <= item.op;
            range0_reg <= item.range_mm;
            last0_reg  <= item.last_sample;
            head0_reg  <= item.heading_error_mrad;
        end
        if (leave0)
        begin
            t1_reg.steer   <= op0_reg;
            t1_reg.heading <= head0_reg;
        end
        if (leave1)
            t2_reg <= t1_reg;
        if (leave2)
            t3_reg <= t2_reg;
    end

    sosl_scan_track #(
        .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (ctl.load1),
        .op          (op0_reg),
        .range_mm    (range0_reg),
        .last_sample (last0_reg),
        .skip_dist   (cfg_reg.skip_dist),
        .last_reg    (s1_last),
        .neg_reg     (s1_neg),
        .absdiff_reg (s1_absdiff),
        .dist_reg    (s1_dist)
    );

    sosl_angle_div #(
        .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES)
    ) u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .last_in     (s1_last),
        .neg_in      (s1_neg),
        .absdiff_in  (s1_absdiff),
        .dist_in     (s1_dist),
        .angle_step  (cfg_reg.angle_step),
        .danger_dist (danger_dist),
        .danger_ang  (danger_ang)
    );

    sosl_steer u_steer (
        .clk          (clk),
        .ctl          (ctl),
        .heading      (t3_reg.heading),
        .danger_dist  (danger_dist),
        .danger_ang   (danger_ang),
        .cfg          (cfg_reg),
        .linear_reg   (linear_reg),
        .rate_reg     (rate_reg),
        .dist_out_reg (dist_out_reg),
        .ang_out_reg  (ang_out_reg)
    );

    // Drive the result channel from the output register
    assign result.valid               = vout_reg;
    assign result.linear_mm_s         = linear_reg;
    assign result.angular_mrad_s      = rate_reg;
    assign result.obstacle_mm         = dist_out_reg;
    assign result.obstacle_angle_mrad = ang_out_reg;

endmodule

// ----- test/tb_scan_obstacle_steer_limiter_core.sv -----
// Self-checking testbench of the scan obstacle steer limiter core with its command predictor.
`timescale 1ns / 100ps

package steer_tb_pkg;
    import sosl_pkg::*;

    // Item operations
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_STEER = 1'b1;

    localparam int NUM_REGS     = int'(REG_ANGLE_STEP) + 1;
    localparam int SCAN_IDX_TOP = 4095;
    localparam int ANG_SAT_HI   = 32767;
    localparam int ANG_SAT_LO   = -32768;

    // One predicted or observed command item
    typedef struct packed {
        logic [15:0] linear;
        logic [16:0] angular;
        logic [15:0] obstacle;
        logic [15:0] obstacle_ang;
    } steer_cmd_t;

    function automatic logic [CFG_W-1:0] reg_default(cfg_idx_t idx);
        case (idx)
            REG_SKIP_DIST:   return RST_SKIP_DIST;
            REG_FRONT_AVOID: return RST_FRONT_AVOID;
            REG_SIDE_AVOID:  return RST_SIDE_AVOID;
            REG_MAX_LINEAR:  return RST_MAX_LINEAR;
            REG_MAX_ANGULAR: return RST_MAX_ANGULAR;
            REG_TURN_GAIN:   return RST_TURN_GAIN;
            REG_ANGLE_STEP:  return RST_ANGLE_STEP;
            default:         return '0;
        endcase
    endfunction

    function automatic int mag_of(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Tracks scans and steering requests, holds the commands still to come out
    class steer_cmd_board;
        logic [CFG_W-1:0] regs [NUM_REGS];
        int               scan_idx;
        int               min_idx;
        int               min_rng;
        int               danger_dist;
        int               danger_ang;
        steer_cmd_t       cmd_q [$];
        int               errors;

        function new();
            for (int i = 0; i < NUM_REGS; i++)
                regs[i] = reg_default(cfg_idx_t'(i));
            scan_idx    = 0;
            min_idx     = 0;
            min_rng     = 0;
            danger_dist = 0;
            danger_ang  = 0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            regs[idx] = value;
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction

        // Advance the running minimum; close the scan on the last sample
        function void track_sample(int rng, logic last);
            longint n;
            longint prod;
            longint q;
            int     skip;
            skip = regs[REG_SKIP_DIST];
            if (scan_idx == 0) begin
                min_idx = 0;
                min_rng = rng;
            end else if (rng < min_rng && rng > skip) begin
                min_idx = scan_idx;
                min_rng = rng;
            end
            if (last) begin
                n    = longint'(scan_idx) + 1;
                prod = (longint'(min_idx) - n / 2) * longint'(int'(regs[REG_ANGLE_STEP]));
                // round half away from zero, then saturate
                q = ((prod < 0 ? -prod : prod) + ROUND_HALF) / DIV_MILLI;
                if (prod < 0)
                    q = -q;
                if (q > ANG_SAT_HI)
                    q = ANG_SAT_HI;
                if (q < ANG_SAT_LO)
                    q = ANG_SAT_LO;
                danger_ang  = int'(q);
                danger_dist = min_rng;
                scan_idx    = 0;
            end else if (scan_idx < SCAN_IDX_TOP) begin
                scan_idx++;
            end
        endfunction

        // Work out the command that one steering request produces
        function steer_cmd_t predict_cmd(logic [HEAD_W-1:0] head);
            int         e;
            int         speed;
            int         lin;
            int         cmd;
            int         aang;
            int         away;
            int         front;
            int         side;
            int         gain;
            int         max_ang;
            longint     rate;
            steer_cmd_t r;
            e       = $signed(head);
            front   = regs[REG_FRONT_AVOID];
            side    = regs[REG_SIDE_AVOID];
            gain    = regs[REG_TURN_GAIN];
            max_ang = regs[REG_MAX_ANGULAR];
            // wrap once into +-pi
            if (mag_of(e) >= HALF_TURN_MRAD)
                e = (e < 0) ? e + FULL_TURN_MRAD : e - FULL_TURN_MRAD;
            speed = regs[REG_MAX_LINEAR];
            if (mag_of(e) > TIER_STOP_MRAD)
                speed = 0;
            else if (mag_of(e) > TIER_HALF_MRAD)
                speed = speed / 2;
            aang = mag_of(danger_ang);
            away = (danger_ang < 0) ? 1 : -1;
            cmd  = e;
            lin  = speed;
            // avoidance overrides apply only while moving
            if (speed != 0) begin
                if (danger_dist < front && aang <= FRONT_CONE_MRAD)
                    cmd = FRONT_STEER * away;
                else if (danger_dist < side && aang <= SIDE_CONE_MRAD)
                    cmd = SIDE_STEER * away;
                if (danger_dist < front && danger_dist >= side && aang <= FRONT_CONE_MRAD)
                    lin = speed * 4 / 5;
                else if (aang <= SIDE_CONE_MRAD && danger_dist < side)
                    lin = speed * 3 / 5;
            end
            rate = (longint'(mag_of(cmd)) * longint'(gain)) >>> 8;
            if (rate > max_ang)
                rate = max_ang;
            if (cmd < 0)
                rate = -rate;
            r.linear       = lin[15:0];
            r.angular      = rate[16:0];
            r.obstacle     = danger_dist[15:0];
            r.obstacle_ang = danger_ang[15:0];
            return r;
        endfunction

        function void note_item(logic op, logic [RANGE_W-1:0] rng, logic last,
                                logic [HEAD_W-1:0] head);
            if (op == OP_SCAN)
                track_sample(int'(rng), last);
            else
                cmd_q.push_back(predict_cmd(head));
        endfunction

        function void check_cmd(steer_cmd_t got);
            steer_cmd_t want;
            if (cmd_q.size() == 0) begin
                $error("command item with no steering request pending");
                errors++;
                return;
            end
            want = cmd_q.pop_front();
            if (got.linear != want.linear) begin
                $error("linear_mm_s: expected %0d, got %0d", want.linear, got.linear);
                errors++;
            end
            if (got.angular != want.angular) begin
                $error("angular_mrad_s: expected %0d, got %0d",
                       $signed(want.angular), $signed(got.angular));
                errors++;
            end
            if (got.obstacle != want.obstacle) begin
                $error("obstacle_mm: expected %0d, got %0d", want.obstacle, got.obstacle);
                errors++;
            end
            if (got.obstacle_ang != want.obstacle_ang) begin
                $error("obstacle_angle_mrad: expected %0d, got %0d",
                       $signed(want.obstacle_ang), $signed(got.obstacle_ang));
                errors++;
            end
        endfunction
    endclass

endpackage

module tb_scan_obstacle_steer_limiter_core;
    import sosl_pkg::*;
    import steer_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 950;
    localparam int PHASE_ITEMS   = 120;
    localparam int LONG_SCAN     = 4100;
    localparam int WIDE_SCAN     = 1200;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    sosl_item_if   item_ch ();
    sosl_result_if result_ch ();

    steer_cmd_board   board = new();
    logic [CFG_W-1:0] cur_regs [NUM_REGS];
    int               cycles = 0;
    int               burst_left;
    int               random_sent;
    int               phase;

    scan_obstacle_steer_limiter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("scan_obstacle_steer_limiter_core regression: fail");
            $finish;
        end
    end

    // Receive command items; stall on a 16-bit ready pattern that is re-chosen at random
    initial
    begin
        int          slot;
        logic [15:0] ready_mask;
        steer_cmd_t  got;
        result_ch.ready = 1'b0;
        slot            = 0;
        ready_mask      = '1;
        forever begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready) begin
                got.linear       = result_ch.linear_mm_s;
                got.angular      = result_ch.angular_mrad_s;
                got.obstacle     = result_ch.obstacle_mm;
                got.obstacle_ang = result_ch.obstacle_angle_mrad;
                board.check_cmd(got);
            end
            if (slot % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_mask = '1;
                    1:       ready_mask = 16'h5555;
                    2:       ready_mask = 16'h0001;
                    default: ready_mask = 16'($urandom()) | 16'h0001;
                endcase
            end
            result_ch.ready <= ready_mask[slot % 16];
            slot++;
        end
    end

    // Send one item in bursts with random gaps; note it once accepted
    task automatic send_item(logic op, logic [RANGE_W-1:0] rng, logic last,
                             logic [HEAD_W-1:0] head);
        int gap;
        bit hold;
        if (burst_left == 0) begin
            gap  = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 8));
            hold = ($urandom_range(0, 29) == 0);
            if (hold && gap == 0)
                gap = 1;
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                // hold off until every command has come out
                if (hold)
                    while (board.pending() != 0)
                        @(posedge clk);
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(40, 120))
                                                    : int'($urandom_range(1, 16));
        end
        item_ch.valid              <= 1'b1;
        item_ch.op                 <= op;
        item_ch.range_mm           <= rng;
        item_ch.last_sample        <= last;
        item_ch.heading_error_mrad <= head;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        board.note_item(op, rng, last, head);
        burst_left--;
    endtask

    // Unused payload fields carry random values
    task automatic send_scan(int rng, logic last);
        send_item(OP_SCAN, rng[RANGE_W-1:0], last, 14'($urandom()));
    endtask

    task automatic send_steer(int head);
        send_item(OP_STEER, 16'($urandom()), 1'($urandom()), head[HEAD_W-1:0]);
    endtask

    // Drop valid, wait for every command, let the pipeline settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all registers from cur_regs, one per clock
    task automatic apply_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= cur_regs[i];
            @(posedge clk);
            board.set_reg(cfg_idx_t'(i), cur_regs[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int clamp16(int v);
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    // Ranges cluster around the skip and avoidance thresholds
    function automatic int pick_range();
        int skip;
        int side;
        int front;
        skip  = cur_regs[REG_SKIP_DIST];
        side  = cur_regs[REG_SIDE_AVOID];
        front = cur_regs[REG_FRONT_AVOID];
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return clamp16(skip + int'($urandom_range(0, 4)) - 2);
            3, 4:    return clamp16(side + int'($urandom_range(0, 600)) - 300);
            5, 6:    return clamp16(front + int'($urandom_range(0, 600)) - 300);
            7:       return int'($urandom_range(0, 3000));
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Headings hit the wrap and tier edges often
    function automatic int pick_heading();
        int v;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 8))
                    0:       v = HALF_TURN_MRAD;
                    1:       v = HALF_TURN_MRAD - 1;
                    2:       v = FULL_TURN_MRAD;
                    3:       v = TIER_STOP_MRAD;
                    4:       v = TIER_STOP_MRAD + 1;
                    5:       v = TIER_HALF_MRAD;
                    6:       v = TIER_HALF_MRAD + 1;
                    7:       v = 0;
                    default: v = 1;
                endcase
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            1:       v = int'($urandom_range(0, 2400)) - 1200;
            default: v = int'($urandom_range(0, 2 * FULL_TURN_MRAD)) - FULL_TURN_MRAD;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value(cfg_idx_t idx);
        int d;
        d = reg_default(idx);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return d[CFG_W-1:0];
            3:       return 16'($urandom_range(0, 65535));
            default: return 16'(clamp16(int'($urandom_range(d / 2, 2 * d))));
        endcase
    endfunction

    // Well-formed scans of random length mixed with steering requests
    task automatic run_random(int count);
        int   scan_len;
        int   scan_pos;
        logic last;
        scan_len = 1;
        scan_pos = 0;
        repeat (count) begin
            if ($urandom_range(0, 9) < 3) begin
                send_steer(pick_heading());
            end else begin
                if (scan_pos == 0)
                    scan_len = ($urandom_range(0, 15) == 0) ? int'($urandom_range(41, 300))
                                                           : int'($urandom_range(1, 40));
                // now and then close a scan early
                last = (scan_pos == scan_len - 1) || ($urandom_range(0, 49) == 0);
                send_scan(pick_range(), last);
                scan_pos = last ? 0 : scan_pos + 1;
            end
        end
        random_sent += count;
    endtask

    initial
    begin
        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = '0;
        cfg_wdata                  = '0;
        item_ch.valid              = 1'b0;
        item_ch.op                 = OP_SCAN;
        item_ch.range_mm           = '0;
        item_ch.last_sample        = 1'b0;
        item_ch.heading_error_mrad = '0;
        burst_left                 = 0;
        random_sent                = 0;
        for (int i = 0; i < NUM_REGS; i++)
            cur_regs[i] = reg_default(cfg_idx_t'(i));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: steer before any scan, zero angle steers negative
        send_steer(0);
        // sample 0 below skip still starts the minimum; equal-to-skip and zero ignored
        send_scan(50, 1'b0);
        send_scan(100, 1'b0);
        send_scan(65535, 1'b0);
        send_scan(0, 1'b1);
        // wrap and tier edges
        send_steer(HALF_TURN_MRAD);
        send_steer(-HALF_TURN_MRAD);
        send_steer(HALF_TURN_MRAD - 1);
        send_steer(FULL_TURN_MRAD);
        send_steer(-FULL_TURN_MRAD);
        send_steer(TIER_STOP_MRAD + 1);
        send_steer(TIER_STOP_MRAD);
        send_steer(TIER_HALF_MRAD + 1);
        send_steer(TIER_HALF_MRAD);
        send_steer(-(TIER_HALF_MRAD + 1));
        // clear ahead
        send_scan(2000, 1'b0);
        send_scan(1500, 1'b1);
        send_steer(0);
        // front zone beyond side distance
        send_scan(700, 1'b0);
        send_scan(800, 1'b1);
        send_steer(0);
        // single-sample scan, close
        send_scan(300, 1'b1);
        send_steer(-(TIER_HALF_MRAD + 1));
        drain();

        // Angle rounding ties in both directions
        cur_regs[REG_ANGLE_STEP] = 16'd1500;
        apply_regs();
        send_scan(200, 1'b0);
        send_scan(300, 1'b1);
        send_steer(0);
        send_scan(500, 1'b0);
        send_scan(400, 1'b0);
        send_scan(300, 1'b1);
        send_steer(0);
        drain();

        // Long scans: index stops at the top, angle saturates both ways
        cur_regs[REG_FRONT_AVOID] = '1;
        cur_regs[REG_SIDE_AVOID]  = '1;
        cur_regs[REG_MAX_ANGULAR] = '1;
        cur_regs[REG_ANGLE_STEP]  = '1;
        apply_regs();
        for (int i = 0; i < LONG_SCAN; i++) begin
            if (i == LONG_SCAN - 3)
                send_scan(3000, 1'b0);
            else if (i == LONG_SCAN - 1)
                send_scan(4000, 1'b1);
            else
                send_scan(5000, 1'b0);
        end
        send_steer(0);
        for (int i = 0; i < WIDE_SCAN; i++)
            send_scan((i == 0) ? 200 : 60000, i == WIDE_SCAN - 1);
        send_steer(0);
        drain();

        // Random phases: all zero, all ones, reset values, then mixed
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                case (phase)
                    0:       cur_regs[i] = '0;
                    1:       cur_regs[i] = '1;
                    2:       cur_regs[i] = reg_default(cfg_idx_t'(i));
                    default: cur_regs[i] = pick_reg_value(cfg_idx_t'(i));
                endcase
            end
            apply_regs();
            run_random(PHASE_ITEMS);
            drain();
            phase++;
        end

        if (board.errors == 0)
            $display("scan_obstacle_steer_limiter_core regression: pass");
        else
            $display("scan_obstacle_steer_limiter_core regression: fail");
        $finish;
    end

endmodule
